@@ hw/rtl/fft_band_spectrum_analyzer_macros.svh @@
`ifndef FFT_BAND_SPECTRUM_ANALYZER_MACROS_SVH
`define FFT_BAND_SPECTRUM_ANALYZER_MACROS_SVH

// same-cycle implication, checked on every rising edge out of reset
`define FBSA_ASSERT_NOW(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked on every rising edge out of reset
`define FBSA_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hw/rtl/fbsa_pkg.sv @@
package fbsa_pkg;

   localparam int IN_W    = 64;
   localparam int OUT_W   = 32;
   localparam int DATA_W  = 32;
   localparam int PROD_W  = 64;
   localparam int MONO_W  = 17;
   localparam int COEF_W  = 16;
   localparam int ROOT_W  = 32;
   localparam int SUM_W   = 36;
   localparam int DIVR_W  = 4;
   localparam int LEVEL_W = 24;
   localparam int BAND_W  = 4;
   localparam int BIN_W   = 6;
   localparam int BAND_TAB = 16;

   localparam logic [LEVEL_W-1:0] LEVEL_MAX = 24'h800000;

   // first and last fft bin of each band
   localparam logic [BIN_W-1:0] BAND_FIRST [BAND_TAB] = '{
      6'd1, 6'd2, 6'd3, 6'd4, 6'd5, 6'd6, 6'd7, 6'd9,
      6'd11, 6'd13, 6'd16, 6'd20, 6'd24, 6'd29, 6'd35, 6'd41};
   localparam logic [BIN_W-1:0] BAND_LAST [BAND_TAB] = '{
      6'd1, 6'd2, 6'd3, 6'd4, 6'd5, 6'd6, 6'd8, 6'd10,
      6'd12, 6'd15, 6'd19, 6'd23, 6'd28, 6'd34, 6'd40, 6'd48};

   typedef enum logic [2:0] {
      ST_FILL, ST_WIN, ST_BFLY, ST_MAG, ST_ROOT, ST_DIV, ST_OUT
   } fbsa_state_type;

   // sin(pi/2 * t) for t in q30, odd polynomial, clamped to [0, 1.0]
   function automatic longint quarter_sine(input longint t);
      longint sq;
      longint p;
      sq = (t * t) >>> 30;
      p = -64'sd3864;
      p = 64'sd172272 + ((p * sq) >>> 30);
      p = -64'sd5026995 + ((p * sq) >>> 30);
      p = 64'sd85569306 + ((p * sq) >>> 30);
      p = -64'sd693598668 + ((p * sq) >>> 30);
      p = 64'sd1686629713 + ((p * sq) >>> 30);
      p = (p * t) >>> 30;
      if (p < 0) p = 0;
      if (p > 64'sd1073741824) p = 64'sd1073741824;
      return p;
   endfunction

   // sine of a 32-bit turn phase, q30
   function automatic longint sine_q30(input logic [31:0] ph);
      longint f;
      longint v;
      f = longint'({32'd0, 2'b00, ph[29:0]});
      if (ph[30]) f = 64'sd1073741824 - f;
      v = quarter_sine(f);
      return ph[31] ? -v : v;
   endfunction

   // q30 to q1.15 with rounding and saturation
   function automatic logic signed [COEF_W-1:0] q30_to_q15(input longint v);
      longint r;
      r = (v + 64'sd16384) >>> 15;
      if (r > 64'sd32767) r = 64'sd32767;
      if (r < -64'sd32768) r = -64'sd32768;
      return COEF_W'(r);
   endfunction

   // round a q15-scaled product back to data width
   function automatic logic signed [DATA_W-1:0] round_q15(input logic signed [PROD_W-1:0] v);
      logic signed [PROD_W-1:0] t;
      t = (v + 64'sd16384) >>> 15;
      return t[DATA_W-1:0];
   endfunction

endpackage

@@ hw/rtl/fft_band_spectrum_analyzer.sv @@
// channel   dir   beat contents
// req_      in    tdata: left_word, right_word
// rsp_      out   tdata: band_index, band_level; tlast: last_band
//
// a sample beat is taken whenever it is offered while the frame fills (req_tready high).
// the beat that completes a frame starts processing, and req_tready stays low
// until the last band beat has been taken: the window pass, the fft butterflies
// (N/2*log2(N) of them), then per band the bin magnitudes, the band average and
// the band beat, all paced by the one shared multiplier and the bit-serial root
// and divide units. rsp_tready low simply holds the band beat.
// reset is synchronous and empties the frame.
module fft_band_spectrum_analyzer #(
   parameter int SAMPLES_PER_FRAME = 128,
   parameter int BAND_COUNT        = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [fbsa_pkg::IN_W-1:0]     req_tdata,   // left_word [31:0], right_word [63:32]
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [fbsa_pkg::OUT_W-1:0]    rsp_tdata,   // band_index [3:0], band_level [27:4]
   output logic                          rsp_tlast
);
   import fbsa_pkg::*;

   localparam int AW   = $clog2(SAMPLES_PER_FRAME);
   localparam int HALF = SAMPLES_PER_FRAME / 2;
   localparam int SW   = $clog2(AW);
   localparam logic [AW-1:0]     LAST_SAMPLE = AW'(SAMPLES_PER_FRAME - 1);
   localparam logic [AW-2:0]     LAST_BFLY   = {(AW-1){1'b1}};
   localparam logic [SW-1:0]     LAST_STAGE  = SW'(AW - 1);
   localparam logic [BAND_W-1:0] LAST_BAND   = BAND_W'(BAND_COUNT - 1);

   fbsa_state_type       state_ff, state_in;
   logic [2:0]           step_ff, step_in;
   logic [AW-1:0]        fill_ff, fill_in;
   logic [AW-1:0]        idx_ff, idx_in;
   logic [AW-2:0]        bcnt_ff, bcnt_in;
   logic [SW-1:0]        stage_ff, stage_in;
   logic [BAND_W-1:0]    band_ff, band_in;
   logic [BIN_W-1:0]     bin_ff, bin_in;
   logic [SUM_W-1:0]     sum_ff, sum_in;
   logic signed [PROD_W-1:0] acc_re_ff, acc_re_in, acc_im_ff, acc_im_in;
   logic [PROD_W-1:0]    sq_ff, sq_in;
   logic [LEVEL_W-1:0]   level_ff, level_in;

   logic signed [MONO_W-1:0]   mono_mem [SAMPLES_PER_FRAME];
   logic signed [MONO_W-1:0]   mono_rd_ff;
   logic signed [MONO_W-1:0]   mono_in;
   logic [2*DATA_W-1:0]        spec_mem [SAMPLES_PER_FRAME];
   logic [2*DATA_W-1:0]        rd_a_ff, rd_b_ff;
   logic                       spec_we, spec_re;
   logic [AW-1:0]              spec_wa, rd_addr_a, rd_addr_b;
   logic [2*DATA_W-1:0]        spec_wd;

   logic signed [COEF_W-1:0]   hann_tab [SAMPLES_PER_FRAME];
   logic signed [COEF_W-1:0]   tw_cos [HALF];
   logic signed [COEF_W-1:0]   tw_sin [HALF];
   logic [AW-1:0]              win_addr;
   logic [AW-2:0]              half_mask, tw_idx;
   logic [AW-1:0]              a_idx, b_idx;

   logic signed [DATA_W-1:0]   mul_a, mul_b;
   logic signed [PROD_W-1:0]   mul_p;
   logic signed [DATA_W-1:0]   a_re, a_im, b_re, b_im, tr, ti;

   logic                       in_acc, out_acc;
   logic                       sqrt_start, sqrt_done, div_start, div_done;
   logic [ROOT_W-1:0]          sqrt_root;
   logic [SUM_W-1:0]           quot;
   logic [DIVR_W-1:0]          bin_count;

   // window and twiddle tables, built at elaboration
   for (genvar g = 0; g < SAMPLES_PER_FRAME; g++) begin : g_hann
      localparam logic [31:0] HannPh =
         32'((64'(g % (SAMPLES_PER_FRAME - 1)) << 32) / (SAMPLES_PER_FRAME - 1));
      assign hann_tab[g] =
         q30_to_q15((64'sd1073741824 - sine_q30(HannPh + 32'h40000000)) >>> 1);
   end
   for (genvar g = 0; g < HALF; g++) begin : g_twid
      localparam logic [31:0] TwPh = 32'((64'(g) << 32) >> AW);
      assign tw_cos[g] = q30_to_q15(sine_q30(TwPh + 32'h40000000));
      assign tw_sin[g] = q30_to_q15(sine_q30(TwPh));
   end

   // bit-reversed load address
   for (genvar g = 0; g < AW; g++) begin : g_brev
      assign win_addr[g] = idx_ff[AW-1-g];
   end

   // butterfly addressing: insert a zero at the stage bit
   assign half_mask = ~({(AW-1){1'b1}} << stage_ff);
   assign a_idx     = AW'(bcnt_ff) + AW'(bcnt_ff & ~half_mask);
   assign b_idx     = a_idx + (AW'(1) << stage_ff);
   assign tw_idx    = (bcnt_ff & half_mask) << (SW'(AW - 1) - stage_ff);

   assign a_re = rd_a_ff[DATA_W-1:0];
   assign a_im = rd_a_ff[2*DATA_W-1:DATA_W];
   assign b_re = rd_b_ff[DATA_W-1:0];
   assign b_im = rd_b_ff[2*DATA_W-1:DATA_W];
   assign tr   = round_q15(acc_re_ff);
   assign ti   = round_q15(acc_im_ff);

   assign mono_in   = MONO_W'($signed(req_tdata[31:16])) + MONO_W'($signed(req_tdata[63:48]));
   assign in_acc    = req_tvalid & req_tready;
   assign out_acc   = rsp_tvalid & rsp_tready;
   assign bin_count = DIVR_W'(BAND_LAST[band_ff] - BAND_FIRST[band_ff] + BIN_W'(1));

   // frame store: written by sample beats, read by the window pass
   always_ff @(posedge clock) begin
      if (in_acc) mono_mem[fill_ff] <= mono_in;
      mono_rd_ff <= mono_mem[idx_ff];
   end

   // spectrum store: one write, two reads
   always_ff @(posedge clock) begin
      if (spec_we) spec_mem[spec_wa] <= spec_wd;
      if (spec_re) begin
         rd_a_ff <= spec_mem[rd_addr_a];
         rd_b_ff <= spec_mem[rd_addr_b];
      end
   end

   // shared multiplier and iterative units
   fbsa_mul u_mul (
      .clock (clock),
      .mul_a (mul_a),
      .mul_b (mul_b),
      .mul_p (mul_p)
   );

   fbsa_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start),
      .radicand (sq_ff),
      .done     (sqrt_done),
      .root     (sqrt_root)
   );

   fbsa_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_ff),
      .divisor  (bin_count),
      .done     (div_done),
      .quotient (quot)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_FILL: if (in_acc && fill_ff == LAST_SAMPLE) state_in = ST_WIN;
         ST_WIN:  if (step_ff == 3'd2 && idx_ff == LAST_SAMPLE) state_in = ST_BFLY;
         ST_BFLY: begin
            if (step_ff == 3'd7 && bcnt_ff == LAST_BFLY && stage_ff == LAST_STAGE)
               state_in = ST_MAG;
         end
         ST_MAG:  if (step_ff == 3'd4) state_in = ST_ROOT;
         ST_ROOT: begin
            if (sqrt_done) state_in = (bin_ff == BAND_LAST[band_ff]) ? ST_DIV : ST_MAG;
         end
         ST_DIV:  if (div_done) state_in = ST_OUT;
         ST_OUT:  if (out_acc) state_in = (band_ff == LAST_BAND) ? ST_FILL : ST_MAG;
         default: state_in = ST_FILL;
      endcase
   end

   // state outputs
   always_comb begin
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      spec_re    = 1'b0;
      spec_we    = 1'b0;
      sqrt_start = 1'b0;
      div_start  = 1'b0;
      case (state_ff)
         ST_FILL: req_tready = 1'b1;
         ST_WIN:  spec_we = (step_ff == 3'd2);
         ST_BFLY: begin
            spec_re = (step_ff == 3'd0);
            spec_we = (step_ff == 3'd6) || (step_ff == 3'd7);
         end
         ST_MAG: begin
            spec_re    = (step_ff == 3'd0);
            sqrt_start = (step_ff == 3'd4);
         end
         ST_DIV:  div_start = (step_ff == 3'd0);
         ST_OUT:  rsp_tvalid = 1'b1;
         default: ;
      endcase
   end

   // multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         ST_WIN: begin
            mul_a = DATA_W'(mono_rd_ff);
            mul_b = DATA_W'(hann_tab[idx_ff]);
         end
         ST_BFLY: begin
            case (step_ff)
               3'd1: begin mul_a = b_re; mul_b = DATA_W'(tw_cos[tw_idx]); end
               3'd2: begin mul_a = b_im; mul_b = DATA_W'(tw_sin[tw_idx]); end
               3'd3: begin mul_a = b_im; mul_b = DATA_W'(tw_cos[tw_idx]); end
               3'd4: begin mul_a = b_re; mul_b = DATA_W'(tw_sin[tw_idx]); end
               default: ;
            endcase
         end
         ST_MAG: begin
            case (step_ff)
               3'd1: begin mul_a = a_re; mul_b = a_re; end
               3'd2: begin mul_a = a_im; mul_b = a_im; end
               default: ;
            endcase
         end
         default: ;
      endcase
   end

   // sequencing counters and datapath registers
   always_comb begin
      step_in   = step_ff;
      fill_in   = fill_ff;
      idx_in    = idx_ff;
      bcnt_in   = bcnt_ff;
      stage_in  = stage_ff;
      band_in   = band_ff;
      bin_in    = bin_ff;
      sum_in    = sum_ff;
      acc_re_in = acc_re_ff;
      acc_im_in = acc_im_ff;
      sq_in     = sq_ff;
      level_in  = level_ff;
      spec_wa   = win_addr;
      spec_wd   = {{DATA_W{1'b0}}, round_q15(mul_p)};
      rd_addr_a = a_idx;
      rd_addr_b = b_idx;
      if (in_acc) fill_in = fill_ff + AW'(1);
      case (state_ff)
         ST_FILL: begin
            step_in  = '0;
            idx_in   = '0;
            bcnt_in  = '0;
            stage_in = '0;
         end
         ST_WIN: begin
            if (step_ff == 3'd2) begin
               step_in = '0;
               idx_in  = idx_ff + AW'(1);
            end else begin
               step_in = step_ff + 3'd1;
            end
         end
         ST_BFLY: begin
            step_in = step_ff + 3'd1;
            case (step_ff)
               3'd2: acc_re_in = mul_p;
               3'd3: acc_re_in = acc_re_ff + mul_p;
               3'd4: acc_im_in = mul_p;
               3'd5: acc_im_in = acc_im_ff - mul_p;
               3'd6: begin
                  spec_wa = a_idx;
                  spec_wd = {a_im + ti, a_re + tr};
               end
               3'd7: begin
                  spec_wa = b_idx;
                  spec_wd = {a_im - ti, a_re - tr};
                  bcnt_in = bcnt_ff + (AW-1)'(1);
                  if (bcnt_ff == LAST_BFLY) stage_in = stage_ff + SW'(1);
                  band_in = '0;
                  bin_in  = BAND_FIRST[0];
                  sum_in  = '0;
               end
               default: ;
            endcase
         end
         ST_MAG: begin
            rd_addr_a = AW'(bin_ff);
            step_in   = (step_ff == 3'd4) ? 3'd0 : step_ff + 3'd1;
            case (step_ff)
               3'd2: sq_in = $unsigned(mul_p);
               3'd3: sq_in = sq_ff + $unsigned(mul_p);
               default: ;
            endcase
         end
         ST_ROOT: begin
            if (sqrt_done) begin
               sum_in = sum_ff + SUM_W'(sqrt_root);
               if (bin_ff != BAND_LAST[band_ff]) bin_in = bin_ff + BIN_W'(1);
            end
         end
         ST_DIV: begin
            if (step_ff == 3'd0) step_in = 3'd1;
            if (div_done) begin
               step_in  = '0;
               level_in = (quot > SUM_W'(LEVEL_MAX)) ? LEVEL_MAX : quot[LEVEL_W-1:0];
            end
         end
         ST_OUT: begin
            if (out_acc && band_ff != LAST_BAND) begin
               band_in = band_ff + BAND_W'(1);
               bin_in  = BAND_FIRST[band_ff + BAND_W'(1)];
               sum_in  = '0;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_FILL;
         step_ff  <= '0;
         fill_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         fill_ff  <= fill_in;
      end
      idx_ff    <= idx_in;
      bcnt_ff   <= bcnt_in;
      stage_ff  <= stage_in;
      band_ff   <= band_in;
      bin_ff    <= bin_in;
      sum_ff    <= sum_in;
      acc_re_ff <= acc_re_in;
      acc_im_ff <= acc_im_in;
      sq_ff     <= sq_in;
      level_ff  <= level_in;
   end

   // band beat
   assign rsp_tdata = {{(OUT_W-LEVEL_W-BAND_W){1'b0}}, level_ff, band_ff};
   assign rsp_tlast = (band_ff == LAST_BAND);

   `include "fft_band_spectrum_analyzer_macros.svh"

   `FBSA_ASSERT_NOW(a_no_req_while_rsp, clock, reset, rsp_tvalid, !req_tready, "sample beat open while band results pending")
   `FBSA_ASSERT_NEXT(a_frame_starts, clock, reset, in_acc && fill_ff == LAST_SAMPLE, state_ff == ST_WIN && fill_ff == '0, "full frame did not start the window pass")
   `FBSA_ASSERT_NEXT(a_last_band_ends, clock, reset, out_acc && rsp_tlast, state_ff == ST_FILL, "last band beat did not return to frame fill")

endmodule

@@ hw/rtl/fbsa_mul.sv @@
module fbsa_mul (
   input  logic                                clock,
   input  logic signed [fbsa_pkg::DATA_W-1:0]  mul_a,
   input  logic signed [fbsa_pkg::DATA_W-1:0]  mul_b,
   output logic signed [fbsa_pkg::PROD_W-1:0]  mul_p
);
   import fbsa_pkg::*;

   logic signed [PROD_W-1:0] prod_ff;

   // registered signed product
   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
   end

   assign mul_p = prod_ff;

endmodule

@@ hw/rtl/fbsa_sqrt.sv @@
module fbsa_sqrt (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [fbsa_pkg::PROD_W-1:0]   radicand,
   output logic                          done,
   output logic [fbsa_pkg::ROOT_W-1:0]   root
);
   import fbsa_pkg::*;

   localparam int REM_W = ROOT_W + 3;
   localparam int CNT_W = $clog2(ROOT_W);

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [PROD_W-1:0]   v_ff, v_in;
   logic [REM_W-1:0]    rem_ff, rem_in;
   logic [REM_W-1:0]    rem_sh, trial;
   logic [ROOT_W-1:0]   root_ff, root_in;

   // one result bit per cycle, two radicand bits shifted in
   always_comb begin
      rem_sh  = {rem_ff[REM_W-3:0], v_ff[PROD_W-1 -: 2]};
      trial   = REM_W'({root_ff, 2'b01});
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      v_in    = v_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         v_in    = radicand;
         rem_in  = '0;
         root_in = '0;
      end else if (busy_ff) begin
         v_in   = v_ff << 2;
         cnt_in = cnt_ff + CNT_W'(1);
         if (rem_sh >= trial) begin
            rem_in  = rem_sh - trial;
            root_in = {root_ff[ROOT_W-2:0], 1'b1};
         end else begin
            rem_in  = rem_sh;
            root_in = {root_ff[ROOT_W-2:0], 1'b0};
         end
         if (cnt_ff == CNT_W'(ROOT_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff  <= cnt_in;
      v_ff    <= v_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

@@ hw/rtl/fbsa_div.sv @@
module fbsa_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [fbsa_pkg::SUM_W-1:0]    dividend,
   input  logic [fbsa_pkg::DIVR_W-1:0]   divisor,
   output logic                          done,
   output logic [fbsa_pkg::SUM_W-1:0]    quotient
);
   import fbsa_pkg::*;

   localparam int CNT_W = $clog2(SUM_W);

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [SUM_W-1:0]    q_ff, q_in;
   logic [DIVR_W-1:0]   rem_ff, rem_in;
   logic [DIVR_W-1:0]   div_ff, div_in;
   logic [DIVR_W:0]     rem_sh;
   logic                ge;

   // restoring division, one quotient bit per cycle
   always_comb begin
      rem_sh  = {rem_ff, q_ff[SUM_W-1]};
      ge      = rem_sh >= {1'b0, div_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      q_in    = q_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         q_in    = dividend;
         rem_in  = '0;
         div_in  = divisor;
      end else if (busy_ff) begin
         q_in   = {q_ff[SUM_W-2:0], ge};
         rem_in = ge ? DIVR_W'(rem_sh - {1'b0, div_ff}) : rem_sh[DIVR_W-1:0];
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(SUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      q_ff   <= q_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign done     = done_ff;
   assign quotient = q_ff;

endmodule

@@ tb/tb_fft_band_spectrum_analyzer.sv @@
module tb_fft_band_spectrum_analyzer;
   import fbsa_pkg::*;

   localparam int FRAME_LEN    = 128;
   localparam int LOG2_FRAME   = 7;
   localparam int BANDS        = 16;
   localparam int STALL_LIMIT  = 200000;
   localparam int SETTLE_TICKS = 12000;
   localparam longint ONE_Q30  = 64'sd1073741824;

   // traffic shaping phases
   typedef enum int {FLOW_FREE, FLOW_SRC_IDLE, FLOW_SNK_STALL, FLOW_BOTH} flow_mode_t;
   // frame content kinds
   typedef enum int {WAVE_NOISE, WAVE_SQUARE, WAVE_QUIET, WAVE_FULL_SQUARE} wave_kind_t;

   typedef struct {
      logic [BAND_W-1:0]  band;
      logic [LEVEL_W-1:0] level;
      logic               last;
   } band_beat_t;

   logic               clock;
   logic               reset;
   logic               req_tvalid = 1'b0;
   logic               req_tready;
   logic [IN_W-1:0]    req_tdata  = '0;   // left_word [31:0], right_word [63:32]
   logic               rsp_tvalid;
   logic               rsp_tready = 1'b0;
   logic [OUT_W-1:0]   rsp_tdata;         // band_index [3:0], band_level [27:4]
   logic               rsp_tlast;

   flow_mode_t  flow_mode  = FLOW_FREE;
   band_beat_t  band_queue[$];
   int          errors     = 0;
   int          beats_in   = 0;
   int          beats_out  = 0;
   int          frames_done = 0;
   longint      tick       = 0;
   longint      hold_until = 0;
   int          quiet_ticks = 0;

   // predictor state
   longint      hann_tab [FRAME_LEN];
   longint      cos_tab  [FRAME_LEN/2];
   longint      sin_tab  [FRAME_LEN/2];
   longint      mono_buf [FRAME_LEN];
   int          mono_fill = 0;
   longint      spec_re  [FRAME_LEN];
   longint      spec_im  [FRAME_LEN];
   int          bin_lo [BANDS] = '{1, 2, 3, 4, 5, 6, 7, 9, 11, 13, 16, 20, 24, 29, 35, 41};
   int          bin_hi [BANDS] = '{1, 2, 3, 4, 5, 6, 8, 10, 12, 15, 19, 23, 28, 34, 40, 48};

   fft_band_spectrum_analyzer u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      clock = 1'b1;
      #4;
      clock = 1'b0;
      #4;
   end

   // ---------------- fixed-point spectrum predictor ----------------

   // sin(pi/2 * t), t in q30, odd polynomial with floor shifts
   function automatic longint qsin(input longint t);
      longint coef [6];
      longint sq;
      longint p;
      coef = '{64'sd1686629713, -64'sd693598668, 64'sd85569306,
               -64'sd5026995, 64'sd172272, -64'sd3864};
      sq = (t * t) >>> 30;
      p = coef[5];
      for (int k = 4; k >= 0; k--) p = coef[k] + ((p * sq) >>> 30);
      p = (p * t) >>> 30;
      if (p < 0) p = 0;
      if (p > ONE_Q30) p = ONE_Q30;
      return p;
   endfunction

   function automatic longint phase_sin(input logic [31:0] ph);
      longint f;
      longint v;
      f = longint'(ph[29:0]);
      if (ph[30]) f = ONE_Q30 - f;
      v = qsin(f);
      return ph[31] ? -v : v;
   endfunction

   function automatic logic [31:0] frac_turn(input int num, input int den);
      logic [63:0] n;
      n = 64'(num % den) << 32;
      return 32'(n / 64'(den));
   endfunction

   function automatic longint to_q15(input longint v);
      longint r;
      r = (v + 64'sd16384) >>> 15;
      if (r > 32767) r = 32767;
      if (r < -32768) r = -32768;
      return r;
   endfunction

   function automatic longint root_floor(input longint v);
      longint r;
      longint c;
      r = 0;
      for (int b = 31; b >= 0; b--) begin
         c = r | (64'sd1 << b);
         if (c * c <= v) r = c;
      end
      return r;
   endfunction

   function automatic void build_tables();
      for (int i = 0; i < FRAME_LEN; i++)
         hann_tab[i] = to_q15((ONE_Q30 - phase_sin(frac_turn(i, FRAME_LEN - 1)
                                                   + 32'h4000_0000)) >>> 1);
      for (int i = 0; i < FRAME_LEN / 2; i++) begin
         cos_tab[i] = to_q15(phase_sin(frac_turn(i, FRAME_LEN) + 32'h4000_0000));
         sin_tab[i] = to_q15(phase_sin(frac_turn(i, FRAME_LEN)));
      end
   endfunction

   // window, fft and band averages of the full frame
   function automatic void spectrum_bands();
      int       d;
      int       half;
      int       stride;
      int       w;
      int       ia;
      int       ib;
      longint   tr;
      longint   ti;
      longint   sum;
      longint   avg;
      band_beat_t bb;
      for (int i = 0; i < FRAME_LEN; i++) begin
         d = 0;
         for (int k = 0; k < LOG2_FRAME; k++) d = (d << 1) | ((i >> k) & 1);
         spec_re[d] = (mono_buf[i] * hann_tab[i] + 64'sd16384) >>> 15;
         spec_im[d] = 0;
      end
      for (int len = 2; len <= FRAME_LEN; len <<= 1) begin
         half = len / 2;
         stride = FRAME_LEN / len;
         for (int s = 0; s < FRAME_LEN; s += len) begin
            for (int j = 0; j < half; j++) begin
               w  = (j * stride) % (FRAME_LEN / 2);
               ia = s + j;
               ib = s + j + half;
               tr = (spec_re[ib] * cos_tab[w] + spec_im[ib] * sin_tab[w] + 64'sd16384) >>> 15;
               ti = (spec_im[ib] * cos_tab[w] - spec_re[ib] * sin_tab[w] + 64'sd16384) >>> 15;
               spec_re[ib] = spec_re[ia] - tr;
               spec_im[ib] = spec_im[ia] - ti;
               spec_re[ia] = spec_re[ia] + tr;
               spec_im[ia] = spec_im[ia] + ti;
            end
         end
      end
      for (int b = 0; b < BANDS; b++) begin
         sum = 0;
         for (int k = bin_lo[b]; k <= bin_hi[b]; k++)
            sum += root_floor(spec_re[k] * spec_re[k] + spec_im[k] * spec_im[k]);
         avg = sum / (bin_hi[b] - bin_lo[b] + 1);
         if (avg > longint'(LEVEL_MAX)) avg = longint'(LEVEL_MAX);
         bb.band  = BAND_W'(b);
         bb.level = LEVEL_W'(avg);
         bb.last  = (b == BANDS - 1);
         band_queue.push_back(bb);
      end
      frames_done++;
   endfunction

   function automatic void absorb_pair(input logic [31:0] lw, input logic [31:0] rw);
      mono_buf[mono_fill] = longint'($signed(lw[31:16])) + longint'($signed(rw[31:16]));
      mono_fill++;
      if (mono_fill == FRAME_LEN) begin
         mono_fill = 0;
         spectrum_bands();
      end
   endfunction

   // ---------------- sender ----------------

   function automatic int idle_pct();
      case (flow_mode)
         FLOW_SRC_IDLE, FLOW_SNK_STALL: return 75;
         FLOW_BOTH: return 23;
         default: return 0;
      endcase
   endfunction

   task automatic send_pair(input logic [31:0] lw, input logic [31:0] rw);
      // random gap before the beat
      if ((flow_mode == FLOW_SRC_IDLE || flow_mode == FLOW_BOTH) &&
          $urandom_range(99) < idle_pct()) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         while ($urandom_range(99) < idle_pct()) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= {rw, lw};
      do @(posedge clock); while (!req_tready);
      absorb_pair(lw, rw);
      beats_in++;
   endtask

   task automatic release_req();
      @(negedge clock);
      req_tvalid <= 1'b0;
   endtask

   function automatic logic [31:0] shaped_word(input wave_kind_t kind, input int idx,
                                               input int period, input int amp);
      logic [15:0] s;
      case (kind)
         WAVE_SQUARE:      s = ((idx % period) < period / 2) ? 16'(amp) : 16'(-amp);
         WAVE_QUIET:       s = 16'($urandom_range(64) - 32);
         WAVE_FULL_SQUARE: s = ((idx % period) < period / 2) ? 16'h7FFF : 16'h8000;
         default:          s = 16'($urandom);
      endcase
      return {s, 16'($urandom)};
   endfunction

   task automatic send_frame_items(input wave_kind_t kind, input int count);
      int period;
      int amp;
      period = 2 * $urandom_range(1, 40);
      amp    = $urandom_range(1, 32767);
      for (int i = 0; i < count; i++)
         send_pair(shaped_word(kind, i, period, amp), shaped_word(kind, i, period, amp));
   endtask

   task automatic wait_for_bands();
      release_req();
      wait (band_queue.size() == 0);
      @(posedge clock);
   endtask

   // ---------------- result checker, stall watchdog ----------------

   always @(negedge clock) begin
      if (tick < hold_until)
         rsp_tready <= 1'b0;
      else if (flow_mode == FLOW_SNK_STALL || flow_mode == FLOW_BOTH)
         rsp_tready <= ($urandom_range(99) >= idle_pct());
      else
         rsp_tready <= 1'b1;
   end

   always @(posedge clock) begin
      band_beat_t want;
      tick <= tick + 1;
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet_ticks <= 0;
      else if (!reset) quiet_ticks <= quiet_ticks + 1;
      if (quiet_ticks >= STALL_LIMIT) begin
         $display("tb_fft_band_spectrum_analyzer: FAIL");
         $finish;
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         beats_out <= beats_out + 1;
         if (band_queue.size() == 0) begin
            $error("unexpected band beat: band_index %0d", rsp_tdata[3:0]);
            errors <= errors + 1;
         end else begin
            want = band_queue.pop_front();
            if (rsp_tdata[3:0] !== want.band) begin
               $error("band_index mismatch: expected %0d, got %0d", want.band, rsp_tdata[3:0]);
               errors <= errors + 1;
            end
            if (rsp_tdata[27:4] !== want.level) begin
               $error("band_level mismatch: expected %0d, got %0d", want.level, rsp_tdata[27:4]);
               errors <= errors + 1;
            end
            if (rsp_tlast !== want.last) begin
               $error("last_band mismatch: expected %0d, got %0d", want.last, rsp_tlast);
               errors <= errors + 1;
            end
         end
      end
   end

   // ---------------- tests ----------------

   // field extremes and ignored low halves, then complete the frame
   task automatic test_extremes();
      logic [31:0] corner [6];
      corner = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_FFFF,
                 32'hFFFF_0000, 32'h0000_0000, 32'hFFFF_FFFF};
      flow_mode = FLOW_FREE;
      for (int i = 0; i < 24; i++) send_pair(corner[i % 6], corner[(i / 6 + i) % 6]);
      send_frame_items(WAVE_NOISE, FRAME_LEN - 24);
   endtask

   // full-scale square tones, the largest band levels the input can give
   task automatic test_full_scale();
      flow_mode = FLOW_FREE;
      send_frame_items(WAVE_FULL_SQUARE, FRAME_LEN);
   endtask

   task automatic test_random_frames(input flow_mode_t mode, input int frames);
      flow_mode = mode;
      for (int f = 0; f < frames; f++)
         send_frame_items(wave_kind_t'($urandom_range(2)), FRAME_LEN);
   endtask

   // sink held off while the source keeps offering beats past a frame boundary
   task automatic test_sink_holdoff();
      flow_mode = FLOW_FREE;
      send_frame_items(WAVE_SQUARE, FRAME_LEN - 1);
      hold_until = tick + 15000;
      send_frame_items(WAVE_NOISE, 21);
      send_frame_items(WAVE_QUIET, FRAME_LEN - 20);
   endtask

   // source pauses until every band of the pending frames is out
   task automatic test_drain_pause();
      wait_for_bands();
      repeat (200) @(posedge clock);
      flow_mode = FLOW_BOTH;
      send_frame_items(WAVE_SQUARE, FRAME_LEN);
   endtask

   initial begin
      build_tables();
      reset = 1'b1;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_extremes();
      test_full_scale();
      test_random_frames(FLOW_FREE, 1);
      test_random_frames(FLOW_SRC_IDLE, 1);
      test_random_frames(FLOW_SNK_STALL, 1);
      test_random_frames(FLOW_BOTH, 1);
      test_sink_holdoff();
      test_drain_pause();

      wait_for_bands();
      repeat (SETTLE_TICKS) @(posedge clock);
      if (band_queue.size() != 0) begin
         $error("%0d band beats never arrived", band_queue.size());
         errors++;
      end
      $display("covered %0d sample beats in %0d frames and %0d band beats,", beats_in,
               frames_done, beats_out);
      $display("with extremes, tones, noise, idle and stall phases and a long sink hold-off");
      if (errors == 0)
         $display("tb_fft_band_spectrum_analyzer: PASS");
      else
         $display("tb_fft_band_spectrum_analyzer: FAIL");
      $finish;
   end

endmodule
